// ----- design/cau_pkg.sv -----
// Shared opcodes, status codes and the threshold reset constant of the complex arithmetic unit.
package cau_pkg;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_SQRT = 3'd4
  } cau_op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DIV_ZERO = 2'd1,
    ST_OVERFLOW = 2'd2
  } cau_status_e;

  localparam logic [15:0] SNAP_THR_RST = 16'd66;

endpackage

// ----- design/cau_div.sv -----
// Pipelined restoring divider: one quotient bit per stage, quotient known to fit QW bits.
module cau_div import cau_pkg::*; #(
  parameter int NW = 80,
  parameter int DW = 64,
  parameter int QW = 32
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quo_o
);

  logic [NW-1:0] rem_q [QW];
  logic [DW-1:0] den_q [QW];
  logic [QW-1:0] quo_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int Sh = QW - 1 - k;
    logic [NW-1:0] rem_s;
    logic [DW-1:0] den_s;
    logic [QW-1:0] quo_s;
    logic          fit;

    if (k == 0) begin : g_first
      assign rem_s = num_i;
      assign den_s = den_i;
      assign quo_s = '0;
    end else begin : g_next
      assign rem_s = rem_q[k-1];
      assign den_s = den_q[k-1];
      assign quo_s = quo_q[k-1];
    end

    // trial subtract of the shifted divisor
    assign fit = (rem_s >> Sh) >= NW'(den_s);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= fit ? (rem_s - (NW'(den_s) << Sh)) : rem_s;
        den_q[k] <= den_s;
        quo_q[k] <= {quo_s[QW-2:0], fit};
      end
    end
  end

  assign quo_o = quo_q[QW-1];

endmodule

// ----- design/cau_sqrt.sv -----
// Pipelined digit-by-digit integer square root: one root bit per stage, floor result.
module cau_sqrt import cau_pkg::*; #(
  parameter int VW = 64
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [VW-1:0]   rad_i,
  output logic [VW/2-1:0] root_o
);

  localparam int HW  = VW / 2;
  localparam int RMW = HW + 2;

  logic [VW-1:0] rad_q  [HW];
  logic [HW-1:0] rem_q  [HW];
  logic [HW-1:0] root_q [HW];

  for (genvar k = 0; k < HW; k++) begin : g_stage
    logic [VW-1:0]  rad_s;
    logic [HW-1:0]  rem_s;
    logic [HW-1:0]  root_s;
    logic [RMW-1:0] acc;
    logic [RMW-1:0] trial;
    logic           fit;

    if (k == 0) begin : g_first
      assign rad_s  = rad_i;
      assign rem_s  = '0;
      assign root_s = '0;
    end else begin : g_next
      assign rad_s  = rad_q[k-1];
      assign rem_s  = rem_q[k-1];
      assign root_s = root_q[k-1];
    end

    // bring down two radicand bits and try root*4+1
    assign acc   = {rem_s, rad_s[VW-1 -: 2]};
    assign trial = {root_s, 2'b01};
    assign fit   = acc >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k]  <= rad_s << 2;
        rem_q[k]  <= fit ? HW'(acc - trial) : HW'(acc);
        root_q[k] <= {root_s[HW-2:0], fit};
      end
    end
  end

  assign root_o = root_q[HW-1];

endmodule

// ----- design/complex_arithmetic_unit_top.sv -----
// Complex arithmetic unit top: fixed-point add, subtract, multiply, divide and square root.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid_i/in_ready_o, opcode, a_*, b_*   | in
//  out     | out_valid_o/out_ready_i, res_*, status    | out
//  cfg     | cfg_valid_i/cfg_ready_o, snap threshold   | in
//
// Takes one item per cycle while the skid register is empty; the pipeline depth is set by
// the magnitude root followed by the half-angle roots.
// Reset clears the pipeline valid bits, the skid register's valid bit and the threshold (to 66).
// The whole pipeline halts only while the skid register holds a result that was not taken.
module complex_arithmetic_unit_top import cau_pkg::*; #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [15:0]                 sqrt_snap_threshold_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [2:0]                  opcode_i,
  input  logic signed [WORD_BITS-1:0] a_re_i,
  input  logic signed [WORD_BITS-1:0] a_im_i,
  input  logic signed [WORD_BITS-1:0] b_re_i,
  input  logic signed [WORD_BITS-1:0] b_im_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [WORD_BITS-1:0] res_re_o,
  output logic signed [WORD_BITS-1:0] res_im_o,
  output logic [1:0]                  status_o
);

  localparam int W   = WORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int PW  = 2 * W;
  localparam int FW  = PW + 1;
  localparam int NW  = PW + F;
  localparam int RW  = (W + F) + ((W + F) % 2);
  localparam int HW  = RW / 2;
  localparam int SD  = W + HW + 1;
  localparam int DL  = W + HW;
  localparam int LAT = 5 + W + HW;

  typedef struct packed {
    logic [2:0]          op;
    logic signed [FW-1:0] fre;
    logic signed [FW-1:0] fim;
    logic signed [W-1:0]  ar;
    logic                 ai_neg;
  } side_t;

  typedef struct packed {
    logic re_neg;
    logic im_neg;
    logic re_big;
    logic im_big;
    logic dz;
  } dinfo_t;

  logic en;
  logic [LAT-1:0] vld_q;
  logic [15:0] thr_q;

  // configuration register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= SNAP_THR_RST;
    end else if (cfg_valid_i) begin
      thr_q <= sqrt_snap_threshold_i;
    end
  end

  // advance every stage together unless the skid register is full
  logic skid_v_q;
  assign en         = !skid_v_q;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  // stage 1: capture the item
  logic [2:0]          op1_q;
  logic signed [W-1:0] ar1_q, ai1_q, br1_q, bi1_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      op1_q <= opcode_i;
      ar1_q <= a_re_i;
      ai1_q <= a_im_i;
      br1_q <= b_re_i;
      bi1_q <= b_im_i;
    end
  end

  // stage 2: products, with the square root reusing the first two for |a|^2
  logic signed [W-1:0]  m1_b, m2_b;
  logic signed [PW-1:0] m1_q, m2_q, m3_q, m4_q, m5_q, m6_q;
  logic signed [W:0]    lin_re_q, lin_im_q;
  logic [2:0]           op2_q;
  logic signed [W-1:0]  ar2_q;
  logic                 ai_neg2_q;

  assign m1_b = (op1_q == OP_SQRT) ? ar1_q : br1_q;
  assign m2_b = (op1_q == OP_SQRT) ? ai1_q : bi1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_q      <= ar1_q * m1_b;
      m2_q      <= ai1_q * m2_b;
      m3_q      <= ar1_q * bi1_q;
      m4_q      <= ai1_q * br1_q;
      m5_q      <= br1_q * br1_q;
      m6_q      <= bi1_q * bi1_q;
      lin_re_q  <= (op1_q == OP_SUB) ? (ar1_q - br1_q) : (ar1_q + br1_q);
      lin_im_q  <= (op1_q == OP_SUB) ? (ai1_q - bi1_q) : (ai1_q + bi1_q);
      op2_q     <= op1_q;
      ar2_q     <= ar1_q;
      ai_neg2_q <= ai1_q[W-1];
    end
  end

  // stage 3: sums of products, direct results for add, subtract and multiply
  logic signed [FW-1:0] sum_p, dif_p, sum_x, dif_x;
  side_t                side3_d, side3_q;
  logic signed [FW-1:0] nre3_q, nim3_q;
  logic [PW-1:0]        d3_q;

  assign sum_p = m1_q + m2_q;
  assign dif_p = m1_q - m2_q;
  assign sum_x = m3_q + m4_q;
  assign dif_x = m4_q - m3_q;

  always_comb begin
    side3_d        = '0;
    side3_d.op     = op2_q;
    side3_d.ar     = ar2_q;
    side3_d.ai_neg = ai_neg2_q;
    case (op2_q) inside
      OP_ADD, OP_SUB: begin
        side3_d.fre = FW'(lin_re_q);
        side3_d.fim = FW'(lin_im_q);
      end
      OP_MUL: begin
        side3_d.fre = dif_p >>> F;
        side3_d.fim = sum_x >>> F;
      end
      default: begin
        side3_d.fre = '0;
        side3_d.fim = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side3_q <= side3_d;
      nre3_q  <= sum_p;
      nim3_q  <= dif_x;
      d3_q    <= $unsigned(m5_q) + $unsigned(m6_q);
    end
  end

  // stage 4: divider setup, magnitudes scaled up and range check
  logic [FW-1:0] mag_re, mag_im;
  logic [NW-1:0] n_re, n_im, n_re4_q, n_im4_q;
  logic [PW-1:0] d4_q;
  dinfo_t        dinfo4_d, dinfo4_q;

  assign mag_re = nre3_q[FW-1] ? -nre3_q : nre3_q;
  assign mag_im = nim3_q[FW-1] ? -nim3_q : nim3_q;
  assign n_re   = {mag_re[PW-1:0], {F{1'b0}}};
  assign n_im   = {mag_im[PW-1:0], {F{1'b0}}};

  always_comb begin
    dinfo4_d.re_neg = nre3_q[FW-1];
    dinfo4_d.im_neg = nim3_q[FW-1];
    dinfo4_d.re_big = (n_re >> W) >= NW'(d3_q);
    dinfo4_d.im_big = (n_im >> W) >= NW'(d3_q);
    dinfo4_d.dz     = (d3_q == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      n_re4_q  <= n_re;
      n_im4_q  <= n_im;
      d4_q     <= d3_q;
      dinfo4_q <= dinfo4_d;
    end
  end

  logic [W-1:0] q_re, q_im;

  cau_div #(.NW(NW), .DW(PW), .QW(W)) u_div_re (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (n_re4_q),
    .den_i (d4_q),
    .quo_o (q_re)
  );

  cau_div #(.NW(NW), .DW(PW), .QW(W)) u_div_im (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (n_im4_q),
    .den_i (d4_q),
    .quo_o (q_im)
  );

  // delay lines for the item's side data and the division results
  side_t        side_q [SD];
  dinfo_t       dl_q   [DL];
  logic [W-1:0] qre_l_q [HW];
  logic [W-1:0] qim_l_q [HW];

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0]  <= side3_q;
      dl_q[0]    <= dinfo4_q;
      qre_l_q[0] <= q_re;
      qim_l_q[0] <= q_im;
      for (int j = 1; j < SD; j++) side_q[j] <= side_q[j-1];
      for (int j = 1; j < DL; j++) dl_q[j] <= dl_q[j-1];
      for (int j = 1; j < HW; j++) begin
        qre_l_q[j] <= qre_l_q[j-1];
        qim_l_q[j] <= qim_l_q[j-1];
      end
    end
  end

  // magnitude |a| = floor(sqrt(a_re^2 + a_im^2))
  logic [W-1:0] mag_m;

  cau_sqrt #(.VW(PW)) u_sqrt_mag (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (nre3_q[PW-1:0]),
    .root_o (mag_m)
  );

  // half-angle radicands, with the imaginary one snapped below the threshold
  logic signed [W+1:0] s_sum, t_dif;
  logic [W:0]          s_u, t_u, t_k;
  logic [RW-1:0]       srad4_q, trad4_q;

  assign s_sum = $signed({2'b00, mag_m}) + side_q[W-1].ar;
  assign t_dif = $signed({2'b00, mag_m}) - side_q[W-1].ar;
  assign s_u   = s_sum[W:0];
  assign t_u   = t_dif[W:0];
  assign t_k   = (t_u < (W+1)'(thr_q)) ? '0 : t_u;

  always_ff @(posedge clk_i) begin
    if (en) begin
      srad4_q <= RW'({s_u, {(F-1){1'b0}}});
      trad4_q <= RW'({t_k, {(F-1){1'b0}}});
    end
  end

  logic [HW-1:0] sr, si;

  cau_sqrt #(.VW(RW)) u_sqrt_re (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (srad4_q),
    .root_o (sr)
  );

  cau_sqrt #(.VW(RW)) u_sqrt_im (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (trad4_q),
    .root_o (si)
  );

  // signed quotient; a quotient that did not fit stands in as 2^W
  function automatic logic signed [FW-1:0] div_val(input logic [W-1:0] q, input logic big,
                                                    input logic neg);
    logic [W:0]          mag;
    logic signed [W+1:0] sv;
    mag = big ? {1'b1, {W{1'b0}}} : {1'b0, q};
    sv  = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    return FW'(sv);
  endfunction

  function automatic logic fits(input logic signed [FW-1:0] x);
    return (&x[FW-1:W-1]) || !(|x[FW-1:W-1]);
  endfunction

  function automatic logic signed [W-1:0] clamp(input logic signed [FW-1:0] x);
    logic signed [W-1:0] r;
    if (fits(x)) r = x[W-1:0];
    else if (x[FW-1]) r = {1'b1, {(W-1){1'b0}}};
    else r = {1'b0, {(W-1){1'b1}}};
    return r;
  endfunction

  // final stage: pick by opcode, saturate, set status
  side_t                side_f;
  dinfo_t               dinfo_f;
  logic signed [FW-1:0] fin_re, fin_im, sq_re, sq_im;
  logic                 dz_f;
  cau_status_e          status_d;
  logic signed [W-1:0]  res_re_q, res_im_q;
  cau_status_e          status_q;

  assign side_f  = side_q[SD-1];
  assign dinfo_f = dl_q[DL-1];
  assign sq_re   = FW'($signed({1'b0, sr}));
  assign sq_im   = side_f.ai_neg ? -FW'($signed({1'b0, si})) : FW'($signed({1'b0, si}));

  always_comb begin
    dz_f = 1'b0;
    case (side_f.op) inside
      OP_ADD, OP_SUB, OP_MUL: begin
        fin_re = side_f.fre;
        fin_im = side_f.fim;
      end
      OP_DIV: begin
        dz_f   = dinfo_f.dz;
        fin_re = dinfo_f.dz ? '0 :
                 div_val(qre_l_q[HW-1], dinfo_f.re_big, dinfo_f.re_neg);
        fin_im = dinfo_f.dz ? '0 :
                 div_val(qim_l_q[HW-1], dinfo_f.im_big, dinfo_f.im_neg);
      end
      OP_SQRT: begin
        fin_re = sq_re;
        fin_im = sq_im;
      end
      default: begin
        fin_re = '0;
        fin_im = '0;
      end
    endcase
    if (dz_f) status_d = ST_DIV_ZERO;
    else if (!fits(fin_re) || !fits(fin_im)) status_d = ST_OVERFLOW;
    else status_d = ST_OK;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_re_q <= clamp(fin_re);
      res_im_q <= clamp(fin_im);
      status_q <= status_d;
    end
  end

  // output skid register: hold a result that was not taken
  logic signed [W-1:0] skid_re_q, skid_im_q;
  cau_status_e         skid_st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      skid_v_q <= !out_ready_i;
    end else begin
      skid_v_q <= vld_q[LAT-1] && !out_ready_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_v_q) begin
      skid_re_q <= res_re_q;
      skid_im_q <= res_im_q;
      skid_st_q <= status_q;
    end
  end

  assign out_valid_o = skid_v_q || vld_q[LAT-1];
  assign res_re_o    = skid_v_q ? skid_re_q : res_re_q;
  assign res_im_o    = skid_v_q ? skid_im_q : res_im_q;
  assign status_o    = skid_v_q ? skid_st_q : status_q;

`ifndef SYNTH
  a_skid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q && !out_ready_i |=> skid_v_q)
    else $error("skid register dropped an item not taken");

  a_skid_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(vld_q[LAT-1]))
    else $error("skid register filled from an empty stage");

  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_DIV_ZERO) |-> (res_re_o == '0) && (res_im_o == '0))
    else $error("division by zero with nonzero result");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == ST_OK) || (status_o == ST_DIV_ZERO) ||
                    (status_o == ST_OVERFLOW))
    else $error("undefined status code");
`endif

endmodule
